### rtl/core/tbe_pkg.sv
`default_nettype none

package tbe_pkg;

    // Default sizes of the tape and the program space.
    localparam int TapeDepth    = 65536;
    localparam int ProgramDepth = 65536;

    // Result status codes.
    localparam logic [1:0] StatusRun   = 2'd0;
    localparam logic [1:0] StatusHalt  = 2'd1;
    localparam logic [1:0] StatusFault = 2'd2;

    // Instruction codes.
    typedef enum logic [4:0] {
        OP_ADD_CONST     = 5'd0,
        OP_SET_CONST     = 5'd1,
        OP_MUL_CONST     = 5'd2,
        OP_ADD_MUL       = 5'd3,
        OP_ADD_CELL      = 5'd4,
        OP_ADD_CLEAR     = 5'd5,
        OP_SUB_CELL      = 5'd6,
        OP_LOAD          = 5'd7,
        OP_LOAD_SWAP     = 5'd8,
        OP_SWAP          = 5'd9,
        OP_LOAD_MUL      = 5'd10,
        OP_ADD_STORE_MUL = 5'd11,
        OP_SQADD_REG     = 5'd12,
        OP_SHIFT         = 5'd13,
        OP_SHIFT_BIG     = 5'd14,
        OP_READ          = 5'd15,
        OP_WRITE         = 5'd16,
        OP_J             = 5'd17,
        OP_JEZ           = 5'd18,
        OP_JNEZ          = 5'd19,
        OP_JEZ_SHIFT     = 5'd20,
        OP_JNEZ_SHIFT    = 5'd21,
        OP_SKIP_LOOP     = 5'd22,
        OP_MARK_EOF      = 5'd23,
        OP_DEBUG_BREAK   = 5'd24
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_EXEC,
        ST_WR2,
        ST_SKIP_RD,
        ST_SKIP_CHK
    } state_t;

endpackage

`default_nettype wire

### rtl/core/tbe_cmd_if.sv
`default_nettype none

interface tbe_cmd_if;
    logic               valid;
    logic               ready;
    logic [4:0]         operation;
    logic signed [16:0] long_operand;
    logic signed [15:0] short_offset;
    logic [7:0]         const_byte;
    logic [7:0]         input_byte;

    modport source (output valid, output operation, output long_operand,
                    output short_offset, output const_byte, output input_byte,
                    input ready);
    modport sink (input valid, input operation, input long_operand,
                  input short_offset, input const_byte, input input_byte,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/tbe_res_if.sv
`default_nettype none

interface tbe_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] next_pc;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [1:0]  status;

    modport source (output valid, output next_pc, output out_valid,
                    output out_byte, output status, input ready);
    modport sink (input valid, input next_pc, input out_valid,
                  input out_byte, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/tape_bytecode_executor.sv
// Bytecode executor on a byte tape.
// The cmd channel takes one instruction per transaction; the res channel
// returns exactly one transaction per instruction with the next program
// counter, an optional output byte and the run status.
// After reset the tape memory is cleared one cell per cycle; cmd.ready
// stays low during that pass. Instructions are executed one at a time by a
// sequencer around a single port tape memory with a registered read: a read
// of the first cell, a read of the second cell, then the write. An ordinary
// instruction passes through ST_RD_A, ST_RD_B and ST_EXEC, plus ST_WR2 for
// the move-and-clear and SWAP, which write two cells; the next instruction
// is accepted only after its finished result has moved into the output
// register. A skip loop alternates ST_SKIP_RD and ST_SKIP_CHK per cell
// visited, at most TAPE_DEPTH cells, and stops with a fault if none is zero.
// Instructions given once the block has stopped are not executed.
// The result stays in an output register until res accepts it; a new
// instruction is accepted meanwhile, and the sequencer holds its finished
// result only if the previous one has not yet been taken.
// TAPE_DEPTH and PROGRAM_DEPTH must be powers of two; the block itself does not enforce it.
`default_nettype none

module tape_bytecode_executor #(
    parameter int TAPE_DEPTH    = tbe_pkg::TapeDepth,
    parameter int PROGRAM_DEPTH = tbe_pkg::ProgramDepth
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tbe_cmd_if.sink    cmd,
    tbe_res_if.source  res
);

    localparam int AW = $clog2(TAPE_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam logic [AW-1:0] PtrInit = AW'(TAPE_DEPTH / 2 - 1);
    localparam logic [AW-1:0] AddrLast = AW'(TAPE_DEPTH - 1);

    // Tape memory.
    logic [7:0] tape_mem [TAPE_DEPTH];
    logic [7:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    tbe_pkg::state_t state_reg, state_next;
    tbe_pkg::op_t    op_reg, op_next;
    logic [16:0]     lo_reg, lo_next;
    logic [7:0]      b_reg, b_next;
    logic [7:0]      ib_reg, ib_next;
    logic [AW-1:0]   addr_a_reg, addr_a_next;
    logic [AW-1:0]   addr_b_reg, addr_b_next;
    logic [7:0]      d_a_reg, d_a_next;
    logic [AW-1:0]   ptr_reg, ptr_next;
    logic [7:0]      scratch_reg, scratch_next;
    logic [PW-1:0]   pc_reg, pc_next;
    logic            stopped_reg, stopped_next;
    logic            fault_reg, fault_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   wr2_addr_reg, wr2_addr_next;
    logic [7:0]      wr2_data_reg, wr2_data_next;
    logic            pend_ov_reg, pend_ov_next;
    logic [7:0]      pend_ob_reg, pend_ob_next;
    logic            done_reg, done_next;
    logic            rv_reg, rv_next;
    logic [PW-1:0]   rpc_reg, rpc_next;
    logic            rov_reg, rov_next;
    logic [7:0]      rob_reg, rob_next;
    logic [1:0]      rst_reg, rst_next;

    logic          accept;
    logic          can_emit;
    logic          needs_wr2;
    logic [AW-1:0] ofs_l, ofs_s;
    logic [PW-1:0] pc_inc, target;
    logic [7:0]    sq_r, sq_m1, sq_m2;
    logic [15:0]   prod;

    assign accept   = cmd.valid && cmd.ready;
    assign can_emit = !rv_reg || res.ready;
    assign ofs_l    = cmd.long_operand[AW-1:0];
    assign ofs_s    = cmd.short_offset[AW-1:0];
    assign pc_inc   = pc_reg + PW'(1);
    assign target   = lo_reg[PW-1:0];
    assign needs_wr2 = (op_reg == tbe_pkg::OP_ADD_CLEAR) || (op_reg == tbe_pkg::OP_SWAP);

    assign cmd.ready     = (state_reg == tbe_pkg::ST_IDLE) && !done_reg;
    assign res.valid     = rv_reg;
    assign res.next_pc   = 16'(rpc_reg);
    assign res.out_valid = rov_reg;
    assign res.out_byte  = rob_reg;
    assign res.status    = rst_reg;

    // Single shared 8x8 multiplier for all product instructions.
    assign sq_r = scratch_reg + 8'd1;
    always_comb
    begin
        sq_m1 = b_reg;
        sq_m2 = d_a_reg;
        case (op_reg)
            tbe_pkg::OP_ADD_MUL:
            begin
                sq_m1 = b_reg;
                sq_m2 = rdata_reg;
            end
            tbe_pkg::OP_ADD_STORE_MUL:
            begin
                sq_m1 = b_reg;
                sq_m2 = scratch_reg;
            end
            tbe_pkg::OP_SQADD_REG:
            begin
                if (d_a_reg[0])
                begin
                    sq_m1 = sq_r >> 1;
                    sq_m2 = d_a_reg;
                end
                else
                begin
                    sq_m1 = d_a_reg >> 1;
                    sq_m2 = sq_r;
                end
            end
            default:
            begin
                sq_m1 = b_reg;
                sq_m2 = d_a_reg;
            end
        endcase
    end
    assign prod = sq_m1 * sq_m2;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbe_pkg::ST_CLEAR:
            begin
                if (cnt_reg == AddrLast)
                    state_next = tbe_pkg::ST_IDLE;
            end
            tbe_pkg::ST_IDLE:
            begin
                if (accept && !stopped_reg)
                begin
                    if (tbe_pkg::op_t'(cmd.operation) == tbe_pkg::OP_SKIP_LOOP)
                        state_next = tbe_pkg::ST_SKIP_RD;
                    else
                        state_next = tbe_pkg::ST_RD_A;
                end
            end
            tbe_pkg::ST_RD_A:     state_next = tbe_pkg::ST_RD_B;
            tbe_pkg::ST_RD_B:     state_next = tbe_pkg::ST_EXEC;
            tbe_pkg::ST_EXEC:
                state_next = needs_wr2 ? tbe_pkg::ST_WR2 : tbe_pkg::ST_IDLE;
            tbe_pkg::ST_WR2:      state_next = tbe_pkg::ST_IDLE;
            tbe_pkg::ST_SKIP_RD:  state_next = tbe_pkg::ST_SKIP_CHK;
            tbe_pkg::ST_SKIP_CHK:
            begin
                if (rdata_reg == 8'd0 || cnt_reg == AddrLast)
                    state_next = tbe_pkg::ST_IDLE;
                else
                    state_next = tbe_pkg::ST_SKIP_RD;
            end
            default:              state_next = tbe_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory control and result handling.
    always_comb
    begin
        op_next       = op_reg;
        lo_next       = lo_reg;
        b_next        = b_reg;
        ib_next       = ib_reg;
        addr_a_next   = addr_a_reg;
        addr_b_next   = addr_b_reg;
        d_a_next      = d_a_reg;
        ptr_next      = ptr_reg;
        scratch_next  = scratch_reg;
        pc_next       = pc_reg;
        stopped_next  = stopped_reg;
        fault_next    = fault_reg;
        cnt_next      = cnt_reg;
        wr2_addr_next = wr2_addr_reg;
        wr2_data_next = wr2_data_reg;
        pend_ov_next  = pend_ov_reg;
        pend_ob_next  = pend_ob_reg;
        done_next     = done_reg;
        rv_next       = rv_reg && !res.ready;
        rpc_next      = rpc_reg;
        rov_next      = rov_reg;
        rob_next      = rob_reg;
        rst_next      = rst_reg;
        mem_we        = 1'b0;
        mem_addr      = addr_a_reg;
        mem_wdata     = 8'd0;

        case (state_reg)
            tbe_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = cnt_reg;
                cnt_next = cnt_reg + AW'(1);
            end
            tbe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = tbe_pkg::op_t'(cmd.operation);
                    lo_next      = cmd.long_operand;
                    b_next       = cmd.const_byte;
                    ib_next      = cmd.input_byte;
                    pend_ov_next = 1'b0;
                    pend_ob_next = 8'd0;
                    cnt_next     = '0;
                    addr_a_next  = ptr_reg + ofs_l;
                    addr_b_next  = ptr_reg + ofs_l + ofs_s;
                    case (tbe_pkg::op_t'(cmd.operation))
                        tbe_pkg::OP_JEZ, tbe_pkg::OP_JNEZ, tbe_pkg::OP_SKIP_LOOP:
                            addr_a_next = ptr_reg;
                        tbe_pkg::OP_JEZ_SHIFT, tbe_pkg::OP_JNEZ_SHIFT:
                            addr_a_next = ptr_reg + ofs_s;
                        default: ;
                    endcase
                    if (stopped_reg)
                        done_next = 1'b1;
                end
            end
            tbe_pkg::ST_RD_A:
            begin
                mem_addr = addr_a_reg;
            end
            tbe_pkg::ST_RD_B:
            begin
                mem_addr = addr_b_reg;
                d_a_next = rdata_reg;
            end
            tbe_pkg::ST_EXEC:
            begin
                // rdata_reg holds the second cell, d_a_reg the first.
                pc_next       = pc_inc;
                mem_addr      = addr_a_reg;
                wr2_addr_next = addr_b_reg;
                wr2_data_next = 8'd0;
                case (op_reg)
                    tbe_pkg::OP_ADD_CONST:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = d_a_reg + b_reg;
                    end
                    tbe_pkg::OP_SET_CONST:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = b_reg;
                    end
                    tbe_pkg::OP_MUL_CONST, tbe_pkg::OP_ADD_STORE_MUL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = prod[7:0];
                    end
                    tbe_pkg::OP_ADD_MUL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = d_a_reg + prod[7:0];
                    end
                    tbe_pkg::OP_ADD_CELL, tbe_pkg::OP_ADD_CLEAR:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = d_a_reg + rdata_reg;
                    end
                    tbe_pkg::OP_SUB_CELL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = d_a_reg - rdata_reg;
                    end
                    tbe_pkg::OP_LOAD:
                        scratch_next = d_a_reg;
                    tbe_pkg::OP_LOAD_SWAP:
                    begin
                        mem_we       = 1'b1;
                        mem_wdata    = scratch_reg;
                        scratch_next = d_a_reg;
                    end
                    tbe_pkg::OP_SWAP:
                    begin
                        // Second cell first, then the first cell in ST_WR2.
                        mem_we        = 1'b1;
                        mem_addr      = addr_b_reg;
                        mem_wdata     = d_a_reg;
                        wr2_addr_next = addr_a_reg;
                        wr2_data_next = rdata_reg;
                    end
                    tbe_pkg::OP_LOAD_MUL, tbe_pkg::OP_SQADD_REG:
                        scratch_next = prod[7:0];
                    tbe_pkg::OP_SHIFT:
                        ptr_next = addr_a_reg;
                    tbe_pkg::OP_READ:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = ib_reg;
                    end
                    tbe_pkg::OP_WRITE:
                    begin
                        pend_ov_next = 1'b1;
                        pend_ob_next = d_a_reg;
                    end
                    tbe_pkg::OP_J:
                        pc_next = target;
                    tbe_pkg::OP_JEZ:
                        if (d_a_reg == 8'd0)
                            pc_next = target;
                    tbe_pkg::OP_JNEZ:
                        if (d_a_reg != 8'd0)
                            pc_next = target;
                    tbe_pkg::OP_JEZ_SHIFT:
                    begin
                        ptr_next = addr_a_reg;
                        if (d_a_reg == 8'd0)
                            pc_next = target;
                    end
                    tbe_pkg::OP_JNEZ_SHIFT:
                    begin
                        ptr_next = addr_a_reg;
                        if (d_a_reg != 8'd0)
                            pc_next = target;
                    end
                    tbe_pkg::OP_MARK_EOF:
                    begin
                        pc_next      = pc_reg;
                        stopped_next = 1'b1;
                        fault_next   = 1'b0;
                    end
                    default: ;
                endcase
                if (!needs_wr2)
                    done_next = 1'b1;
            end
            tbe_pkg::ST_WR2:
            begin
                mem_we    = 1'b1;
                mem_addr  = wr2_addr_reg;
                mem_wdata = wr2_data_reg;
                done_next = 1'b1;
            end
            tbe_pkg::ST_SKIP_RD:
            begin
                mem_addr = addr_a_reg;
            end
            tbe_pkg::ST_SKIP_CHK:
            begin
                if (rdata_reg == 8'd0)
                begin
                    ptr_next  = addr_a_reg;
                    pc_next   = pc_inc;
                    done_next = 1'b1;
                end
                else if (cnt_reg == AddrLast)
                begin
                    stopped_next = 1'b1;
                    fault_next   = 1'b1;
                    done_next    = 1'b1;
                end
                else
                begin
                    cnt_next    = cnt_reg + AW'(1);
                    addr_a_next = addr_a_reg + lo_reg[AW-1:0];
                end
            end
            default: ;
        endcase

        // Move a finished result into the output register.
        if (done_reg && can_emit)
        begin
            done_next = 1'b0;
            rv_next   = 1'b1;
            rpc_next  = pc_reg;
            rov_next  = pend_ov_reg;
            rob_next  = pend_ob_reg;
            if (!stopped_reg)
                rst_next = tbe_pkg::StatusRun;
            else if (fault_reg)
                rst_next = tbe_pkg::StatusFault;
            else
                rst_next = tbe_pkg::StatusHalt;
        end
    end

    // Tape memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tape_mem[mem_addr] <= mem_wdata;
        rdata_reg <= tape_mem[mem_addr];
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tbe_pkg::ST_CLEAR;
            op_reg       <= tbe_pkg::OP_ADD_CONST;
            lo_reg       <= '0;
            b_reg        <= '0;
            ib_reg       <= '0;
            addr_a_reg   <= '0;
            addr_b_reg   <= '0;
            d_a_reg      <= '0;
            ptr_reg      <= PtrInit;
            scratch_reg  <= '0;
            pc_reg       <= '0;
            stopped_reg  <= 1'b0;
            fault_reg    <= 1'b0;
            cnt_reg      <= '0;
            wr2_addr_reg <= '0;
            wr2_data_reg <= '0;
            pend_ov_reg  <= 1'b0;
            pend_ob_reg  <= '0;
            done_reg     <= 1'b0;
            rv_reg       <= 1'b0;
            rpc_reg      <= '0;
            rov_reg      <= 1'b0;
            rob_reg      <= '0;
            rst_reg      <= tbe_pkg::StatusRun;
        end
        else
        begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            lo_reg       <= lo_next;
            b_reg        <= b_next;
            ib_reg       <= ib_next;
            addr_a_reg   <= addr_a_next;
            addr_b_reg   <= addr_b_next;
            d_a_reg      <= d_a_next;
            ptr_reg      <= ptr_next;
            scratch_reg  <= scratch_next;
            pc_reg       <= pc_next;
            stopped_reg  <= stopped_next;
            fault_reg    <= fault_next;
            cnt_reg      <= cnt_next;
            wr2_addr_reg <= wr2_addr_next;
            wr2_data_reg <= wr2_data_next;
            pend_ov_reg  <= pend_ov_next;
            pend_ob_reg  <= pend_ob_next;
            done_reg     <= done_next;
            rv_reg       <= rv_next;
            rpc_reg      <= rpc_next;
            rov_reg      <= rov_next;
            rob_reg      <= rob_next;
            rst_reg      <= rst_next;
        end
    end

endmodule

`default_nettype wire
